// ===== rtl/core/spw_pkg.sv =====
// Shared widths, reset values and register codes for the steering PID core.
// Used by steering_pid_wheel_speed_core and spw_checker; no dependencies.
`timescale 1ns / 1ps

package spw_pkg;

  localparam int ERR_W      = 12;
  localparam int BIAS_W     = 13;
  localparam int DELTA_W    = 14;
  localparam int INTEG_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 8;
  localparam int DRIVE_W    = 13;
  localparam int WHEEL_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam int DRIVE_LIMIT_DEFAULT     = 4000;
  localparam int SPEED_SCALE_DIV_DEFAULT = 40;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RESET = 16'd768;

  // output tdata layout
  localparam int OUT_DRIVE_LSB  = 0;
  localparam int OUT_LUPD_BIT   = 13;
  localparam int OUT_LSPD_LSB   = 14;
  localparam int OUT_RUPD_BIT   = 23;
  localparam int OUT_RSPD_LSB   = 24;
  localparam int OUT_USED_W     = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_TARGET_ERROR = 3'd3,
    REG_CRUISE_SPEED = 3'd4
  } cfg_reg_t;

endpackage

// ===== rtl/core/steering_pid_wheel_speed_core.sv =====
// Differential steering PID: error sample in, clamped drive and wheel targets out.
// Depends on spw_pkg for widths, reset values and register codes.
// Throughput 1 item per cycle while the output is not stalled by m_tready.
// Four registered stages: bias and integral, gain products, sum and clamp, wheel targets.
// Integral saturation and bias history update in the cycle an item is taken.
// Synchronous active-high reset clears valids, integral and bias history, restores config defaults.
`timescale 1ns / 1ps

module steering_pid_wheel_speed_core #(
  parameter int DRIVE_LIMIT     = spw_pkg::DRIVE_LIMIT_DEFAULT,
  parameter int SPEED_SCALE_DIV = spw_pkg::SPEED_SCALE_DIV_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [spw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [11:0] position_error, [15:12] zero
  input  logic [spw_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [12:0] steer_drive, [13] left_update, [22:14] left_speed,
  // [23] right_update, [32:24] right_speed, [39:33] zero
  output logic [spw_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int BW  = spw_pkg::BIAS_W;
  localparam int DLW = spw_pkg::DELTA_W;
  localparam int IW  = spw_pkg::INTEG_W;
  localparam int PPW = spw_pkg::GAIN_W + 1 + BW;
  localparam int PIW = spw_pkg::GAIN_W + 1 + IW;
  localparam int PDW = spw_pkg::GAIN_W + 1 + DLW;
  localparam int AW  = PIW + 1;
  localparam int DW  = 16;
  localparam int MAG_W = DW - 1;
  localparam int DIV_L = $clog2(SPEED_SCALE_DIV);
  localparam int DIV_S = MAG_W + DIV_L;
  localparam longint unsigned DIV_R =
    ((64'd1 << DIV_S) + longint'(SPEED_SCALE_DIV) - 64'd1) / longint'(SPEED_SCALE_DIV);
  localparam int REC_W = MAG_W + 2;
  localparam int QP_W  = MAG_W + REC_W;
  localparam int TW    = DW + 2;

  localparam logic signed [AW-1:0] LIM_HI = AW'(DRIVE_LIMIT);
  localparam logic signed [AW-1:0] LIM_LO = -AW'(DRIVE_LIMIT);
  localparam logic signed [IW:0] INT_MAX = (IW+1)'({1'b0, {(IW-1){1'b1}}});
  localparam logic signed [IW:0] INT_MIN = -(IW+1)'({1'b0, {(IW-1){1'b1}}}) - (IW+1)'(1);

  // configuration registers
  logic [spw_pkg::GAIN_W-1:0]         prop_gain;
  logic [spw_pkg::GAIN_W-1:0]         integ_gain;
  logic [spw_pkg::GAIN_W-1:0]         deriv_gain;
  logic signed [spw_pkg::ERR_W-1:0]   target_error;
  logic [spw_pkg::SPEED_W-1:0]        cruise_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= spw_pkg::PROP_GAIN_RESET;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      target_error <= '0;
      cruise_speed <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spw_pkg::REG_PROP_GAIN:    prop_gain    <= cfg_data;
        spw_pkg::REG_INTEG_GAIN:   integ_gain   <= cfg_data;
        spw_pkg::REG_DERIV_GAIN:   deriv_gain   <= cfg_data;
        spw_pkg::REG_TARGET_ERROR: target_error <= cfg_data[spw_pkg::ERR_W-1:0];
        spw_pkg::REG_CRUISE_SPEED: cruise_speed <= cfg_data[spw_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables
  logic v1, v2, v3;
  logic en1, en2, en3, en4;
  logic take;

  assign en4      = !m_tvalid || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign take     = s_tvalid && s_tready;

  // stage 1: bias, saturating integral (cleared on zero bias), bias difference
  logic signed [IW-1:0]  integral;
  logic signed [BW-1:0]  prev_bias;
  logic signed [spw_pkg::ERR_W-1:0] pos_err;
  logic signed [BW-1:0]  bias;
  logic signed [IW:0]    int_sum;
  logic signed [IW-1:0]  integral_next;
  logic signed [DLW-1:0] delta;
  logic signed [BW-1:0]  s1_bias;
  logic signed [IW-1:0]  s1_integral;
  logic signed [DLW-1:0] s1_delta;

  always_comb begin
    pos_err = s_tdata[spw_pkg::ERR_W-1:0];
    bias    = BW'(pos_err) - BW'(target_error);
    int_sum = (IW+1)'(integral) + (IW+1)'(bias);
    if (bias == '0) begin
      integral_next = '0;
    end else if (int_sum > INT_MAX) begin
      integral_next = INT_MAX[IW-1:0];
    end else if (int_sum < INT_MIN) begin
      integral_next = INT_MIN[IW-1:0];
    end else begin
      integral_next = int_sum[IW-1:0];
    end
    delta = DLW'(bias) - DLW'(prev_bias);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral  <= '0;
      prev_bias <= '0;
      v1        <= 1'b0;
    end else begin
      if (take) begin
        integral  <= integral_next;
        prev_bias <= bias;
      end
      if (en1) begin
        v1 <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_bias     <= bias;
      s1_integral <= integral_next;
      s1_delta    <= delta;
    end
  end

  // stage 2: gain products
  logic signed [PPW-1:0] p_prop,  s2_prop;
  logic signed [PIW-1:0] p_integ, s2_integ;
  logic signed [PDW-1:0] p_deriv, s2_deriv;

  always_comb begin
    p_prop  = PPW'($signed({1'b0, prop_gain}))  * PPW'(s1_bias);
    p_integ = PIW'($signed({1'b0, integ_gain})) * PIW'(s1_integral);
    p_deriv = PDW'($signed({1'b0, deriv_gain})) * PDW'(s1_delta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_prop  <= p_prop;
      s2_integ <= p_integ;
      s2_deriv <= p_deriv;
    end
  end

  // stage 3: sum, scale toward zero, clamp
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] drive_c;
  logic signed [DW-1:0] s3_drive;

  always_comb begin
    acc   = AW'(s2_prop) + AW'(s2_integ) + AW'(s2_deriv);
    acc_q = acc >>> 8;
    if (acc[AW-1] && (acc[7:0] != 8'd0)) begin
      acc_q = acc_q + AW'(1);
    end
    if (acc_q > LIM_HI) begin
      drive_c = LIM_HI;
    end else if (acc_q < LIM_LO) begin
      drive_c = LIM_LO;
    end else begin
      drive_c = acc_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3_drive <= drive_c[DW-1:0];
    end
  end

  // stage 4: speed correction and wheel targets
  logic [MAG_W-1:0]         mag;
  logic [QP_W-1:0]          quot_prod;
  logic [QP_W-1:0]          quot_shift;
  logic signed [TW-1:0]     corr;
  logic signed [TW-1:0]     left_t;
  logic signed [TW-1:0]     right_t;
  logic                     left_upd, right_upd;
  logic [spw_pkg::WHEEL_W-1:0] left_spd, right_spd;
  logic [spw_pkg::OUT_TDATA_W-1:0] tdata_next;

  always_comb begin
    mag        = s3_drive[DW-1] ? MAG_W'(-s3_drive) : s3_drive[MAG_W-1:0];
    quot_prod  = QP_W'(mag) * QP_W'(DIV_R);
    quot_shift = quot_prod >> DIV_S;
    corr       = TW'(quot_shift[MAG_W-1:0]);
    if (s3_drive[DW-1]) begin
      corr = -corr;
    end
    left_t  = TW'(cruise_speed) - corr;
    right_t = TW'(cruise_speed) + corr;

    left_upd = !left_t[TW-1];
    if (left_t[TW-1]) begin
      left_spd = '0;
    end else if (left_t > TW'(2**spw_pkg::WHEEL_W - 1)) begin
      left_spd = '1;
    end else begin
      left_spd = left_t[spw_pkg::WHEEL_W-1:0];
    end

    right_upd = !right_t[TW-1];
    if (right_t[TW-1]) begin
      right_spd = '0;
    end else if (right_t > TW'(2**spw_pkg::WHEEL_W - 1)) begin
      right_spd = '1;
    end else begin
      right_spd = right_t[spw_pkg::WHEEL_W-1:0];
    end

    tdata_next = '0;
    tdata_next[spw_pkg::OUT_DRIVE_LSB +: spw_pkg::DRIVE_W] = s3_drive[spw_pkg::DRIVE_W-1:0];
    tdata_next[spw_pkg::OUT_LUPD_BIT] = left_upd;
    tdata_next[spw_pkg::OUT_LSPD_LSB +: spw_pkg::WHEEL_W] = left_spd;
    tdata_next[spw_pkg::OUT_RUPD_BIT] = right_upd;
    tdata_next[spw_pkg::OUT_RSPD_LSB +: spw_pkg::WHEEL_W] = right_spd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en4) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      m_tdata <= tdata_next;
    end
  end

endmodule

// ===== rtl/core/spw_checker.sv =====
// Port-level checks for steering_pid_wheel_speed_core, attached by bind.
// Depends on spw_pkg for the output field layout.
`timescale 1ns / 1ps

module spw_checker #(
  parameter int DRIVE_LIMIT = spw_pkg::DRIVE_LIMIT_DEFAULT
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [spw_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic signed [spw_pkg::DRIVE_W-1:0] drive;
  logic                               lupd, rupd;
  logic [spw_pkg::WHEEL_W-1:0]        lspd, rspd;

  assign drive = m_tdata[spw_pkg::OUT_DRIVE_LSB +: spw_pkg::DRIVE_W];
  assign lupd  = m_tdata[spw_pkg::OUT_LUPD_BIT];
  assign rupd  = m_tdata[spw_pkg::OUT_RUPD_BIT];
  assign lspd  = m_tdata[spw_pkg::OUT_LSPD_LSB +: spw_pkg::WHEEL_W];
  assign rspd  = m_tdata[spw_pkg::OUT_RSPD_LSB +: spw_pkg::WHEEL_W];

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_no_update_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (lupd || lspd == '0) && (rupd || rspd == '0))
    else $error("wheel speed nonzero without update");

  a_drive_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (DRIVE_LIMIT <= 4095) |->
      (drive <= DRIVE_LIMIT) && (drive >= -DRIVE_LIMIT))
    else $error("drive beyond limit");

  a_steer_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && lupd && rupd && (DRIVE_LIMIT <= 4095) && !drive[spw_pkg::DRIVE_W-1]
      |-> rspd >= lspd)
    else $error("wheel targets disagree with drive sign");

endmodule

bind steering_pid_wheel_speed_core spw_checker #(
  .DRIVE_LIMIT(DRIVE_LIMIT)
) u_spw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
